// ===== rtl/mcr_pkg.sv =====
// Package for the Moravec corner response block.
// Types and constants shared by the cells and the top level. No dependencies.
`timescale 1ns / 1ps
package mcr_pkg;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 20;
  localparam int CFG_W   = 12;
  localparam int THR_W   = 20;
  localparam int POS_W   = 11;
  localparam int MIN_DIM = 5;
  localparam int ROW_W   = 18;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH     = 12'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT    = 12'd480;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 20'd15000;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

  // three squares of up to 255^2 need 18 bits
  function automatic logic [ROW_W-1:0] sqdiff3(input pix_t a0, input pix_t b0,
                                               input pix_t a1, input pix_t b1,
                                               input pix_t a2, input pix_t b2);
    logic [8:0] d0, d1, d2;
    d0 = (a0 > b0) ? {1'b0, a0 - b0} : {1'b0, b0 - a0};
    d1 = (a1 > b1) ? {1'b0, a1 - b1} : {1'b0, b1 - a1};
    d2 = (a2 > b2) ? {1'b0, a2 - b2} : {1'b0, b2 - a2};
    sqdiff3 = ROW_W'(d0[7:0] * d0[7:0]) + ROW_W'(d1[7:0] * d1[7:0])
            + ROW_W'(d2[7:0] * d2[7:0]);
  endfunction
endpackage

// ===== rtl/moravec_corner_response.sv =====
// Top level of the Moravec corner response block.
// Depends on mcr_pkg, mcr_line_buf and mcr_col_cell.
//
// channel | dir | signals
// cfg     | in  | psel penable pwrite paddr pwdata prdata pready
// pixel   | in  | valid ready pixel start_of_frame
// result  | out | out_valid out_ready response is_corner center_row center_col last_of_frame
//
// One pixel per clock unless the output stalls. Registers in order: line memory
// read, window shift, row sums, output register with the minimum. The whole pipe
// advances when the output register is free. Reset clears counters, valids and
// configuration registers; the line memory is not reset, and is written before any emitted result reads it.
`timescale 1ns / 1ps
module moravec_corner_response import mcr_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             valid,
  output logic             ready,
  input  logic [7:0]       pixel,
  input  logic             start_of_frame,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [19:0]      response,
  output logic             is_corner,
  output logic [10:0]      center_row,
  output logic [10:0]      center_col,
  output logic             last_of_frame
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int CW = AW + 1;
  localparam int RW = HW + 1;

  logic [CFG_W-1:0] image_width, image_height;
  logic [THR_W-1:0] corner_threshold;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= RST_WIDTH;
      image_height     <= RST_HEIGHT;
      corner_threshold <= RST_THRESHOLD;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WIDTH:     image_width      <= pwdata[CFG_W-1:0];
        REG_HEIGHT:    image_height     <= pwdata[CFG_W-1:0];
        REG_THRESHOLD: corner_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:     prdata = {20'd0, image_width};
      REG_HEIGHT:    prdata = {20'd0, image_height};
      REG_THRESHOLD: prdata = {12'd0, corner_threshold};
      default:       prdata = '0;
    endcase
  end

  // clamped geometry
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  always_comb begin
    if (image_width < CFG_W'(MIN_DIM))        w = CW'(MIN_DIM);
    else if (32'(image_width) > MAX_WIDTH)    w = CW'(MAX_WIDTH);
    else                                      w = CW'(image_width);
    if (image_height < CFG_W'(MIN_DIM))       h = RW'(MIN_DIM);
    else if (32'(image_height) > MAX_HEIGHT)  h = RW'(MAX_HEIGHT);
    else                                      h = RW'(image_height);
  end

  // pipeline: s1 memory read, s2 window, s3 row sums, output register
  logic adv;
  assign adv   = !out_valid || out_ready;
  assign ready = adv;
  logic acc;
  assign acc = valid && ready;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] c0, c_inc;
  logic [RW-1:0] r0, r1, r_inc;
  always_comb begin
    c0 = start_of_frame ? '0 : col_count;
    r0 = start_of_frame ? '0 : row_count;
    r1 = r0;
    if (c0 >= w) begin
      c0 = '0;
      r1 = r0 + 1'b1;
    end
    if (r1 >= h) r1 = '0;
    c_inc = c0 + 1'b1;
    r_inc = r1;
    if (c_inc >= w) begin
      c_inc = '0;
      r_inc = r1 + 1'b1;
      if (r_inc >= h) r_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      col_count <= c_inc;
      row_count <= r_inc;
    end
  end

  pix_t lb_rd [4];
  mcr_line_buf #(.MaxWidth(MAX_WIDTH)) u_lb (
    .clk(clk), .en(acc), .addr(c0[AW-1:0]), .slot(r1[1:0]),
    .wdata(pixel), .rdata(lb_rd)
  );

  logic v1, v2, v3;
  tag_t t1, t2, t3;
  pix_t px1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2 && t2.emit;
    end
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      px1     <= pixel;
      t1.emit <= (r1 >= RW'(4)) && (c0 >= CW'(4));
      t1.last <= (r1 == h - 1'b1) && (c0 == w - 1'b1);
      t1.row  <= POS_W'(r1 - RW'(2));
      t1.col  <= POS_W'(c0 - CW'(2));
    end
    if (adv) begin
      t2 <= t1;
      t3 <= t2;
    end
  end

  // chain of five column cells; cell 4 is newest
  pix_t col_in [5];
  pix_t win [5][5];
  always_comb begin
    for (int k = 0; k < 4; k++) col_in[k] = lb_rd[k];
    col_in[4] = px1;
  end
  for (genvar i = 0; i < 5; i++) begin : g_cell
    if (i == 4) begin : g_head
      mcr_col_cell u_cell (
        .clk(clk), .shift(adv && v1),
        .in_col(col_in),
        .out_col(win[i])
      );
    end else begin : g_body
      mcr_col_cell u_cell (
        .clk(clk), .shift(adv && v1),
        .in_col(win[i+1]),
        .out_col(win[i])
      );
    end
  end

  // stage 3: per-row partial sums of the four shifts
  logic [ROW_W-1:0] up_r [3], dn_r [3], lf_r [3], rt_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        up_r[j] <= sqdiff3(win[1][j+1], win[0][j+1], win[2][j+1], win[1][j+1],
                           win[3][j+1], win[2][j+1]);
        dn_r[j] <= sqdiff3(win[1][j+1], win[2][j+1], win[2][j+1], win[3][j+1],
                           win[3][j+1], win[4][j+1]);
        lf_r[j] <= sqdiff3(win[j+1][1], win[j+1][0], win[j+1][2], win[j+1][1],
                           win[j+1][3], win[j+1][2]);
        rt_r[j] <= sqdiff3(win[j+1][1], win[j+1][2], win[j+1][2], win[j+1][3],
                           win[j+1][3], win[j+1][4]);
      end
    end
  end

  logic [SUM_W-1:0] s_up, s_dn, s_lf, s_rt, m0, m1, best;
  assign s_up = SUM_W'(up_r[0]) + SUM_W'(up_r[1]) + SUM_W'(up_r[2]);
  assign s_dn = SUM_W'(dn_r[0]) + SUM_W'(dn_r[1]) + SUM_W'(dn_r[2]);
  assign s_lf = SUM_W'(lf_r[0]) + SUM_W'(lf_r[1]) + SUM_W'(lf_r[2]);
  assign s_rt = SUM_W'(rt_r[0]) + SUM_W'(rt_r[1]) + SUM_W'(rt_r[2]);
  assign m0   = (s_dn < s_up) ? s_dn : s_up;
  assign m1   = (s_rt < s_lf) ? s_rt : s_lf;
  assign best = (m1 < m0) ? m1 : m0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      response      <= best;
      is_corner     <= best >= corner_threshold;
      center_row    <= t3.row;
      center_col    <= t3.col;
      last_of_frame <= t3.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(response))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    ready == (!out_valid || out_ready))
    else $error("ready mismatch");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> center_row >= 11'd2 && center_col >= 11'd2)
    else $error("border pixel emitted");
`endif
endmodule

// ===== rtl/mcr_col_cell.sv =====
// One column cell of the 5x5 window: holds five pixels and passes them left.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
module mcr_col_cell import mcr_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  pix_t in_col  [5],
  output pix_t out_col [5]
);
  pix_t col [5];
  always_ff @(posedge clk) begin
    if (shift) begin
      col <= in_col;
    end
  end
  assign out_col = col;
endmodule

// ===== rtl/mcr_line_buf.sv =====
// Four line buffers in one memory, one word of four pixels per column.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
module mcr_line_buf import mcr_pkg::*; #(
  parameter int MaxWidth = 2048
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [$clog2(MaxWidth)-1:0] addr,
  input  logic [1:0]                  slot,
  input  pix_t                        wdata,
  output pix_t                        rdata [4]
);
  logic [4*PIX_W-1:0] mem [MaxWidth];
  logic [4*PIX_W-1:0] rd;
  logic [1:0]         slot_q;

  always_ff @(posedge clk) begin
    if (en) begin
      rd     <= mem[addr];
      slot_q <= slot;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr][slot*PIX_W +: PIX_W] <= wdata;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata[k] = rd[2'(2'(k) + slot_q)*PIX_W +: PIX_W];
    end
  end
endmodule
